/* rtl/chm_pkg.sv */
// ----------------------------------------------------------------------------
// chm_pkg
// Shared constants and operation codes for the chained hash map.
// ----------------------------------------------------------------------------
`default_nettype none
package chm_pkg;

  localparam int BUCKETS     = 1024;
  localparam int POOL_NODES  = 4096;
  localparam int BLOCK_BYTES = 4096;

  localparam int BKT_W     = $clog2(BUCKETS);
  localparam int BLK_SHIFT = $clog2(BLOCK_BYTES);
  localparam int KEY_W     = 32;
  localparam int SLOT_W    = 20;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

endpackage
`default_nettype wire

/* rtl/chm_head_tbl.sv */
// ----------------------------------------------------------------------------
// chm_head_tbl
// Bucket head memory with a clearing sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none
module chm_head_tbl
  import chm_pkg::*;
#(
  parameter int NW = 12
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             rd_en,
  input  wire logic [BKT_W-1:0] rd_addr,
  output logic                  rd_valid,
  output logic [NW-1:0]         rd_idx,
  input  wire logic             wr_en,
  input  wire logic [BKT_W-1:0] wr_addr,
  input  wire logic             wr_valid,
  input  wire logic [NW-1:0]    wr_idx,
  output logic                  busy
);

  logic [NW:0]      mem [BUCKETS];
  logic [NW:0]      rdata_r;
  logic             busy_r;
  logic [BKT_W-1:0] clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      clr_r  <= '0;
    end else if (busy_r) begin
      clr_r <= clr_r + 1'b1;
      if (clr_r == BKT_W'(BUCKETS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // sweep writes win; the controller holds off while busy
  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= {wr_valid, wr_idx};
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign rd_valid = rdata_r[NW];
  assign rd_idx   = rdata_r[NW-1:0];
  assign busy     = busy_r;

endmodule
`default_nettype wire

/* rtl/chm_node_pool.sv */
// ----------------------------------------------------------------------------
// chm_node_pool
// Node memory: key, slot, next-valid and next link per node.
// ----------------------------------------------------------------------------
`default_nettype none
module chm_node_pool
  import chm_pkg::*;
#(
  parameter int POOL = POOL_NODES,
  parameter int NW   = 12,
  parameter int DW   = KEY_W + SLOT_W + 1 + NW
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [NW-1:0] rd_addr,
  output logic [DW-1:0]      rd_data,
  input  wire logic          wr_en,
  input  wire logic [NW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [POOL];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  assign rd_data = rdata_r;

endmodule
`default_nettype wire

/* rtl/chained_hash_map_block_tag.sv */
// Flow: the bucket head is read, then the chain is walked with one node read per
//   cycle; an insert from the free list adds a POP step and a delete adds a FREE
//   step before DONE loads the output register. Only one item is worked on at a
//   time; a new input is taken only in IDLE.
// Reset: synchronous, active low; afterwards all BUCKETS (1024) entries of the
//   bucket table are swept clear while in_stall stays high.
// ----------------------------------------------------------------------------
// chained_hash_map_block_tag
// Hash map from block byte offset to cache slot with per-bucket chains in a
// node pool; freed nodes are kept on a LIFO list linked through the next-link field.
// ----------------------------------------------------------------------------
`default_nettype none
module chained_hash_map_block_tag
  import chm_pkg::*;
#(
  parameter int POOL = POOL_NODES
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_mode,
  input  wire logic [KEY_W-1:0]  in_key_offset,
  input  wire logic [SLOT_W-1:0] in_slot_in,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_found,
  output logic [SLOT_W-1:0]      out_slot_out,
  output logic                   out_pool_full
);

  localparam int NW = $clog2(POOL);
  localparam int DW = KEY_W + SLOT_W + 1 + NW;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_HEAD = 7'b0000010,
    S_NODE = 7'b0000100,
    S_MISS = 7'b0001000,
    S_POP  = 7'b0010000,
    S_FREE = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // item under work
  logic [1:0]        op_r;
  logic [KEY_W-1:0]  key_r;
  logic [SLOT_W-1:0] slot_r;
  logic [BKT_W-1:0]  bkt;

  // chain walk context
  logic              hv_r, hv_nxt;
  logic [NW-1:0]     hidx_r, hidx_nxt;
  logic [NW-1:0]     cur_r, cur_nxt;
  logic              pv_r, pv_nxt;
  logic [NW-1:0]     prev_r, prev_nxt;
  logic [KEY_W-1:0]  pkey_r, pkey_nxt;
  logic [SLOT_W-1:0] pslot_r, pslot_nxt;

  // pool bookkeeping
  logic [NW-1:0]     free_head_r, free_head_nxt;
  logic [NW:0]       free_cnt_r, free_cnt_nxt;
  logic [NW:0]       fresh_r, fresh_nxt;

  // pending result
  logic              rfound_r, rfound_nxt;
  logic [SLOT_W-1:0] rslot_r, rslot_nxt;
  logic              rfull_r, rfull_nxt;

  // output register
  logic              ov_r, ov_nxt;
  logic              ofound_r, ofull_r;
  logic [SLOT_W-1:0] oslot_r;

  // memory ports
  logic              h_re, h_we, h_wv, h_rv, h_busy;
  logic [BKT_W-1:0]  h_raddr;
  logic [NW-1:0]     h_widx, h_ridx;
  logic              n_re, n_we;
  logic [NW-1:0]     n_raddr, n_waddr;
  logic [DW-1:0]     n_wdata, n_rdata;

  logic [KEY_W-1:0]  nd_key;
  logic [SLOT_W-1:0] nd_slot;
  logic              nd_nv;
  logic [NW-1:0]     nd_next;
  logic              in_xfer;

  assign bkt     = key_r[BLK_SHIFT +: BKT_W];
  assign nd_key  = n_rdata[DW-1 -: KEY_W];
  assign nd_slot = n_rdata[NW+SLOT_W -: SLOT_W];
  assign nd_nv   = n_rdata[NW];
  assign nd_next = n_rdata[NW-1:0];

  // accept only when idle and the bucket sweep is over
  assign in_stall = (state_r != S_IDLE) || h_busy;
  assign in_xfer  = in_valid && !in_stall;

  chm_head_tbl #(.NW(NW)) u_head (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (h_re),
    .rd_addr  (h_raddr),
    .rd_valid (h_rv),
    .rd_idx   (h_ridx),
    .wr_en    (h_we),
    .wr_addr  (bkt),
    .wr_valid (h_wv),
    .wr_idx   (h_widx),
    .busy     (h_busy)
  );

  chm_node_pool #(.POOL(POOL), .NW(NW), .DW(DW)) u_pool (
    .clk     (clk),
    .rd_en   (n_re),
    .rd_addr (n_raddr),
    .rd_data (n_rdata),
    .wr_en   (n_we),
    .wr_addr (n_waddr),
    .wr_data (n_wdata)
  );

  always_comb begin
    state_nxt     = state_r;
    hv_nxt        = hv_r;
    hidx_nxt      = hidx_r;
    cur_nxt       = cur_r;
    pv_nxt        = pv_r;
    prev_nxt      = prev_r;
    pkey_nxt      = pkey_r;
    pslot_nxt     = pslot_r;
    free_head_nxt = free_head_r;
    free_cnt_nxt  = free_cnt_r;
    fresh_nxt     = fresh_r;
    rfound_nxt    = rfound_r;
    rslot_nxt     = rslot_r;
    rfull_nxt     = rfull_r;
    h_re          = 1'b0;
    h_raddr       = in_key_offset[BLK_SHIFT +: BKT_W];
    h_we          = 1'b0;
    h_wv          = 1'b0;
    h_widx        = '0;
    n_re          = 1'b0;
    n_raddr       = '0;
    n_we          = 1'b0;
    n_waddr       = '0;
    n_wdata       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          h_re      = 1'b1;
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        // head entry is back: clear the result and start the walk
        hv_nxt     = h_rv;
        hidx_nxt   = h_ridx;
        pv_nxt     = 1'b0;
        rfound_nxt = 1'b0;
        rslot_nxt  = '0;
        rfull_nxt  = 1'b0;
        if (op_r == MODE_NONE) begin
          state_nxt = S_DONE;
        end else if (!h_rv) begin
          state_nxt = S_MISS;
        end else begin
          n_re      = 1'b1;
          n_raddr   = h_ridx;
          cur_nxt   = h_ridx;
          state_nxt = S_NODE;
        end
      end
      S_NODE: begin
        if (nd_key == key_r) begin
          rfound_nxt = 1'b1;
          rslot_nxt  = nd_slot;
          if (op_r == MODE_DELETE) begin
            // unlink: splice the successor into the predecessor or the head
            if (pv_r) begin
              n_we    = 1'b1;
              n_waddr = prev_r;
              n_wdata = {pkey_r, pslot_r, nd_nv, nd_next};
            end else begin
              h_we   = 1'b1;
              h_wv   = nd_nv;
              h_widx = nd_next;
            end
            state_nxt = S_FREE;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (nd_nv) begin
          pv_nxt    = 1'b1;
          prev_nxt  = cur_r;
          pkey_nxt  = nd_key;
          pslot_nxt = nd_slot;
          n_re      = 1'b1;
          n_raddr   = nd_next;
          cur_nxt   = nd_next;
        end else begin
          state_nxt = S_MISS;
        end
      end
      S_MISS: begin
        state_nxt = S_DONE;
        if (op_r == MODE_INSERT) begin
          if (free_cnt_r != '0) begin
            // fetch the link of the free-list head before popping it
            n_re      = 1'b1;
            n_raddr   = free_head_r;
            state_nxt = S_POP;
          end else if (fresh_r < (NW+1)'(POOL)) begin
            n_we      = 1'b1;
            n_waddr   = fresh_r[NW-1:0];
            n_wdata   = {key_r, slot_r, hv_r, hidx_r};
            h_we      = 1'b1;
            h_wv      = 1'b1;
            h_widx    = fresh_r[NW-1:0];
            fresh_nxt = fresh_r + 1'b1;
          end else begin
            rfull_nxt = 1'b1;
          end
        end
      end
      S_POP: begin
        n_we          = 1'b1;
        n_waddr       = free_head_r;
        n_wdata       = {key_r, slot_r, hv_r, hidx_r};
        h_we          = 1'b1;
        h_wv          = 1'b1;
        h_widx        = free_head_r;
        free_head_nxt = nd_next;
        free_cnt_nxt  = free_cnt_r - 1'b1;
        state_nxt     = S_DONE;
      end
      S_FREE: begin
        // push the removed node on the free list
        n_we          = 1'b1;
        n_waddr       = cur_r;
        n_wdata       = {key_r, rslot_r, free_cnt_r != '0, free_head_r};
        free_head_nxt = cur_r;
        free_cnt_nxt  = free_cnt_r + 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (!ov_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register: load from DONE when the slot is free, drop on transfer
  always_comb begin
    ov_nxt = ov_r;
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
    if (state_r == S_DONE && (!ov_r || !out_stall)) begin
      ov_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ov_r        <= 1'b0;
      free_cnt_r  <= '0;
      fresh_r     <= '0;
      free_head_r <= '0;
    end else begin
      state_r     <= state_nxt;
      ov_r        <= ov_nxt;
      free_cnt_r  <= free_cnt_nxt;
      fresh_r     <= fresh_nxt;
      free_head_r <= free_head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r   <= in_mode;
      key_r  <= in_key_offset;
      slot_r <= in_slot_in;
    end
    hv_r     <= hv_nxt;
    hidx_r   <= hidx_nxt;
    cur_r    <= cur_nxt;
    pv_r     <= pv_nxt;
    prev_r   <= prev_nxt;
    pkey_r   <= pkey_nxt;
    pslot_r  <= pslot_nxt;
    rfound_r <= rfound_nxt;
    rslot_r  <= rslot_nxt;
    rfull_r  <= rfull_nxt;
    if (state_r == S_DONE && (!ov_r || !out_stall)) begin
      ofound_r <= rfound_r;
      oslot_r  <= rslot_r;
      ofull_r  <= rfull_r;
    end
  end

  assign out_valid     = ov_r;
  assign out_found     = ofound_r;
  assign out_slot_out  = oslot_r;
  assign out_pool_full = ofull_r;

endmodule
`default_nettype wire

/* rtl/chm_checker.sv */
// ----------------------------------------------------------------------------
// chm_checker
// Port-level checks on the result channel of the hash map.
// ----------------------------------------------------------------------------
`default_nettype none
module chm_checker
  import chm_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic              out_found,
  input wire logic [SLOT_W-1:0] out_slot_out,
  input wire logic              out_pool_full
);

  a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_pool_full && out_found))
    else $error("pool_full together with found");

  a_miss_zero_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_slot_out == '0))
    else $error("nonzero slot on a miss");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_slot_out)))
    else $error("stalled result changed");

endmodule

bind chained_hash_map_block_tag chm_checker u_chm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_found     (out_found),
  .out_slot_out  (out_slot_out),
  .out_pool_full (out_pool_full)
);
`default_nettype wire
